/* sv/round_robin_schedule_sim_defines.svh */
// Assertion macros shared by the checker files.
`ifndef ROUND_ROBIN_SCHEDULE_SIM_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULE_SIM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrs assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrs assertion failed");

`endif

/* sv/rrs_pkg.sv */
// Package: types, sizes and state codes of the round-robin scheduler.
`default_nettype none
package rrs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int ARR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int QUANT_W = 16;

  localparam logic [QUANT_W-1:0] QUANT_RST = 16'd4;

  typedef struct packed {
    logic [ARR_W-1:0]   arrive;
    logic [BURST_W-1:0] left;
    logic [ID_W-1:0]    id;
  } slot_t;

  typedef struct packed {
    logic                arrived;
    logic                fits;
    logic [TIME_W-1:0]   sum;
    logic [BURST_W-1:0]  left_rem;
  } alu_res_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage
`default_nettype wire

/* sv/rrs_ring.sv */
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none
module rrs_ring #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/rrs_alu.sv */
// Shared time unit: arrival and quantum compares, saturating time add.
`default_nettype none
module rrs_alu (
  input  wire [rrs_pkg::TIME_W-1:0]  sim_time,
  input  rrs_pkg::slot_t             slot,
  input  wire [rrs_pkg::QUANT_W-1:0] quantum,
  output rrs_pkg::alu_res_t          res
);
  import rrs_pkg::*;

  logic [TIME_W-1:0] add_op;
  logic [TIME_W:0]   sum_w;

  always_comb begin
    res.arrived  = {{(TIME_W-ARR_W){1'b0}}, slot.arrive} <= sim_time;
    res.fits     = slot.left <= quantum;
    res.left_rem = slot.left - quantum;
    if (!res.arrived) begin
      add_op = {{(TIME_W-1){1'b0}}, 1'b1};
    end else if (res.fits) begin
      add_op = {{(TIME_W-BURST_W){1'b0}}, slot.left};
    end else begin
      add_op = {{(TIME_W-QUANT_W){1'b0}}, quantum};
    end
    sum_w   = {1'b0, sim_time} + {1'b0, add_op};
    res.sum = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];
  end

endmodule
`default_nettype wire

/* sv/round_robin_schedule_sim.sv */
// Top level: round-robin scheduler, task loading and run sequencer.
//
// Tasks load one item per cycle into a 16-entry queue; a task offered while the
// queue is full is dropped. The item with in_tlast set loads its task and starts
// the run, during which in_tready is low. The run works through the queue turn
// by turn: a turn either completes the head task, requeues it after one quantum,
// or, when it has not yet arrived, requeues it after one time unit; once the
// queue is empty, the run closes and loading resumes. The single shared
// compare/add unit works on the queue head each cycle, but a completing turn
// stalls while the result register waits on out_tready.
// out_tlast marks the last completion of a run. cfg_wr_en writes the quantum
// (0 acts as 1) and should only be used while no run is in progress.
`default_nettype none
module round_robin_schedule_sim (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_wr_en,
  input  wire [15:0] cfg_wr_data,   // quantum
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [39:0] in_tdata,      // task_id[7:0], burst_time[23:8], arrival_time[39:24]
  input  wire        in_tlast,      // last_task
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [39:0] out_tdata,    // done_id[7:0], finish_time[39:8]
  output logic       out_tlast      // run_end
);
  import rrs_pkg::*;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [QUANT_W-1:0]  quantum_r;
  logic [QUANT_W-1:0]  q_eff;

  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic                out_end_r, out_end_nxt;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  slot_t               wr_data;
  slot_t               rd_slot;
  slot_t               ram_q;
  slot_t               in_slot;
  alu_res_t            alu_res;

  logic                byp_hit;
  logic                byp_r;
  slot_t               byp_data_r;

  logic [CNT_W:0]      tail_sum;
  logic [IDX_W-1:0]    tail_idx;
  logic [IDX_W-1:0]    head_inc;
  logic                in_acc;
  logic                out_busy;

  // head entry is read ahead at the next head index; a write to that entry is forwarded
  rrs_ring #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (MAX_TASKS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_data),
    .rd_addr (head_nxt),
    .rd_data (ram_q)
  );

  rrs_alu u_alu (
    .sim_time (time_r),
    .slot     (rd_slot),
    .quantum  (q_eff),
    .res      (alu_res)
  );

  assign q_eff    = (quantum_r == '0) ? {{(QUANT_W-1){1'b0}}, 1'b1} : quantum_r;
  assign in_slot  = '{arrive: in_tdata[39:24], left: in_tdata[23:8], id: in_tdata[7:0]};
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc   = in_tvalid && in_tready;
  assign out_busy = out_valid_r && !out_tready;
  assign rd_slot  = byp_r ? byp_data_r : ram_q;
  assign byp_hit  = wr_en && (wr_idx == head_nxt);

  always_comb begin
    tail_sum = {{(CNT_W+1-IDX_W){1'b0}}, head_r} + {1'b0, count_r};
    if (tail_sum >= (CNT_W+1)'(MAX_TASKS)) begin
      tail_sum = tail_sum - (CNT_W+1)'(MAX_TASKS);
    end
    tail_idx = tail_sum[IDX_W-1:0];
    head_inc = (head_r == IDX_W'(MAX_TASKS - 1)) ? '0 : head_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_time_nxt  = out_time_r;
    out_end_nxt   = out_end_r;
    wr_en         = 1'b0;
    wr_idx        = tail_idx;
    wr_data       = rd_slot;
    case (state_r)
      ST_LOAD: begin
        wr_data = in_slot;
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_TASKS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_RUN;
            time_nxt  = '0;
          end
        end
      end
      ST_RUN: begin
        if (count_r == '0) begin
          state_nxt = ST_LOAD;
          head_nxt  = '0;
          time_nxt  = '0;
        end else if (!alu_res.arrived) begin
          wr_en    = 1'b1;
          head_nxt = head_inc;
          time_nxt = alu_res.sum;
        end else if (alu_res.fits) begin
          if (!out_busy) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = rd_slot.id;
            out_time_nxt  = alu_res.sum;
            out_end_nxt   = (count_r == CNT_W'(1));
            head_nxt      = head_inc;
            count_nxt     = count_r - 1'b1;
            time_nxt      = alu_res.sum;
          end
        end else begin
          wr_en        = 1'b1;
          wr_data.left = alu_res.left_rem;
          head_nxt     = head_inc;
          time_nxt     = alu_res.sum;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        head_nxt  = '0;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      head_r      <= '0;
      count_r     <= '0;
      time_r      <= '0;
      quantum_r   <= QUANT_RST;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= byp_hit;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
    out_end_r  <= out_end_nxt;
    byp_data_r <= wr_data;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_id_r};
  assign out_tlast  = out_end_r;

endmodule
`default_nettype wire

/* sv/rrs_checker.sv */
// Port checker for the round-robin scheduler, bound to the top level.
`default_nettype none
`include "round_robin_schedule_sim_defines.svh"
module rrs_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        cfg_wr_en,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tlast,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire        out_tlast
);
  import rrs_pkg::*;

  `RRS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RRS_ASSERT_NEXT(a_out_last_hold, out_tvalid && !out_tready, $stable(out_tlast))
  `RRS_ASSERT_NEXT(a_run_blocks_input, in_tvalid && in_tready && in_tlast, !in_tready)
  `RRS_ASSERT_NOW(a_result_during_run, $rose(out_tvalid), !in_tready)
  `RRS_ASSERT_NOW(a_cfg_when_idle, cfg_wr_en, in_tready && !out_tvalid)

endmodule

bind round_robin_schedule_sim rrs_checker u_rrs_checker (.*);
`default_nettype wire
